### rtl/preemptive_priority_scheduler_defines.svh
// assertion macros used by the scheduler port checks
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH

// property checked outside reset
`define PPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// property checked at every edge, reset included
`define PPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/pps_pkg.sv
// types and constants of the preemptive priority scheduler
package pps_pkg;

  localparam int MAX_PROCESSES = 16;
  localparam int IDX_W         = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int COUNT_W       = $clog2(MAX_PROCESSES + 1);

  localparam int TIME_W = 16;
  localparam int BURST_W = 16;
  localparam int PRIO_W = 8;
  localparam int SLOT_W = 6;
  localparam int KIND_W = 2;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RUN  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_IDLE = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]  result_kind;
    logic [SLOT_W-1:0]  process_slot;
    logic               load_rejected;
    logic [TIME_W-1:0]  time_now;
    logic               first_run;
    logic [TIME_W-1:0]  response_time;
    logic               completed;
    logic [TIME_W-1:0]  turnaround_time;
    logic [TIME_W-1:0]  waiting_time;
    logic               all_finished;
  } res_t;

  typedef struct packed {
    logic [TIME_W-1:0]  arrival;
    logic [BURST_W-1:0] burst;
    logic [BURST_W-1:0] remain;
    logic [PRIO_W-1:0]  prio;
  } entry_t;

endpackage

### rtl/pps_if.sv
// request and result channels of the scheduler
interface pps_req_if import pps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [TIME_W-1:0]  arrival_time;
  logic [BURST_W-1:0] burst_time;
  logic [PRIO_W-1:0]  priority_level;

  modport source (output valid, output req_type, output arrival_time, output burst_time,
                  output priority_level, input ready);
  modport sink   (input valid, input req_type, input arrival_time, input burst_time,
                  input priority_level, output ready);
endinterface

interface pps_res_if import pps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  result_kind;
  logic [SLOT_W-1:0]  process_slot;
  logic               load_rejected;
  logic [TIME_W-1:0]  time_now;
  logic               first_run;
  logic [TIME_W-1:0]  response_time;
  logic               completed;
  logic [TIME_W-1:0]  turnaround_time;
  logic [TIME_W-1:0]  waiting_time;
  logic               all_finished;

  modport source (output valid, output result_kind, output process_slot,
                  output load_rejected, output time_now, output first_run,
                  output response_time, output completed, output turnaround_time,
                  output waiting_time, output all_finished, input ready);
  modport sink   (input valid, input result_kind, input process_slot,
                  input load_rejected, input time_now, input first_run,
                  input response_time, input completed, input turnaround_time,
                  input waiting_time, input all_finished, output ready);
endinterface

### rtl/preemptive_priority_scheduler.sv
// preemptive priority scheduler: process table, time counter, serial winner scan
//
// req_i takes one item per transfer: req_type 0 loads a process (arrival, burst,
// priority) into the next free slot, req_type 1 runs one time unit. res_o gives
// exactly one result per request, held in an output register until transferred.
// req_i.ready is high only while the sequencer is idle; one request is in work
// at a time, and the next one can be taken the cycle after a result is registered.
// a load writes its slot unless rejected and goes straight to the output step.
// a tick scans the table one entry per cycle through the single read port of
// the process memory and one shared priority compare, then reads back and
// updates the winner; an idle tick ends after the scan. a result waiting on a
// stalled res_o keeps the next request in the final sequencer step; a new
// request may be taken while that result waits. reset clears the time counter,
// the fill count, the started and finished flags and the output register;
// table entries are written by loads and by the winner update of a tick, and
// entries at or above the fill count are never looked at.
module preemptive_priority_scheduler import pps_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  pps_req_if.sink    req_i,
  pps_res_if.source  res_o
);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_READ, S_UPD, S_FIN, S_OUT} state_e;

  state_e               state_q;
  logic [TIME_W-1:0]    time_q;
  logic [COUNT_W-1:0]   count_q;
  logic [MAX_PROCESSES-1:0] started_q;
  logic [MAX_PROCESSES-1:0] finished_q;
  logic [COUNT_W-1:0]   scan_idx_q;
  logic                 cmp_vld_q;
  logic [IDX_W-1:0]     cmp_idx_q;
  logic                 found_q;
  logic [PRIO_W-1:0]    best_pri_q;
  logic [IDX_W-1:0]     win_idx_q;
  res_t                 res_q;
  res_t                 out_q;
  logic                 out_valid_q;

  entry_t               mem_q [MAX_PROCESSES];
  entry_t               rd_q;

  logic                 req_fire;
  logic                 table_full;
  logic                 issue;
  logic                 cand_ok;
  logic [TIME_W-1:0]    time_inc;
  logic [BURST_W-1:0]   rem_next;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  entry_t               wr_data;
  logic [IDX_W-1:0]     rd_addr;
  logic                 all_done;
  logic                 out_load;
  res_t                 load_res;
  res_t                 res_fin;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign table_full  = (count_q == COUNT_W'(MAX_PROCESSES));
  assign issue       = (scan_idx_q < count_q);
  assign time_inc    = (time_q == TIME_MAX) ? time_q : time_q + TIME_W'(1);
  assign rem_next    = (rd_q.remain != '0) ? rd_q.remain - BURST_W'(1) : rd_q.remain;
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || res_o.ready);

  // one compare per cycle against the best candidate so far
  assign cand_ok = cmp_vld_q && !finished_q[cmp_idx_q] && (rd_q.arrival <= time_q) &&
                   (!found_q || (rd_q.prio < best_pri_q));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = win_idx_q;
    wr_data = rd_q;
    wr_data.remain = rem_next;
    if (state_q == S_IDLE) begin
      wr_addr        = count_q[IDX_W-1:0];
      wr_data.arrival = req_i.arrival_time;
      wr_data.burst   = req_i.burst_time;
      wr_data.remain  = req_i.burst_time;
      wr_data.prio    = req_i.priority_level;
      wr_en = req_fire && (req_i.req_type == REQ_LOAD) && !table_full &&
              (req_i.burst_time != '0);
    end else if (state_q == S_UPD) begin
      wr_en = 1'b1;
    end
  end

  assign rd_addr = (state_q == S_SCAN) ? scan_idx_q[IDX_W-1:0] : win_idx_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[rd_addr];
  end

  // slots at or above the fill count count as finished
  always_comb begin
    all_done = 1'b1;
    for (int i = 0; i < MAX_PROCESSES; i++) begin
      if ((COUNT_W'(i) < count_q) && !finished_q[i]) begin
        all_done = 1'b0;
      end
    end
  end

  always_comb begin
    load_res = '0;
    load_res.result_kind = KIND_LOAD;
    if (wr_en) begin
      load_res.process_slot = SLOT_W'(count_q[IDX_W-1:0]);
    end else begin
      load_res.load_rejected = 1'b1;
    end
  end

  always_comb begin
    res_fin = res_q;
    res_fin.time_now     = time_q;
    res_fin.all_finished = all_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      time_q      <= '0;
      count_q     <= '0;
      started_q   <= '0;
      finished_q  <= '0;
      scan_idx_q  <= '0;
      cmp_vld_q   <= 1'b0;
      cmp_idx_q   <= '0;
      found_q     <= 1'b0;
      best_pri_q  <= '0;
      win_idx_q   <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (req_fire) begin
            if (req_i.req_type == REQ_LOAD) begin
              res_q <= load_res;
              if (wr_en) begin
                started_q[count_q[IDX_W-1:0]]  <= 1'b0;
                finished_q[count_q[IDX_W-1:0]] <= 1'b0;
                count_q <= count_q + COUNT_W'(1);
              end
              state_q <= S_OUT;
            end else begin
              res_q      <= '0;
              scan_idx_q <= '0;
              cmp_vld_q  <= 1'b0;
              found_q    <= 1'b0;
              state_q    <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          cmp_vld_q <= issue;
          cmp_idx_q <= scan_idx_q[IDX_W-1:0];
          if (issue) begin
            scan_idx_q <= scan_idx_q + COUNT_W'(1);
          end
          if (cand_ok) begin
            found_q    <= 1'b1;
            best_pri_q <= rd_q.prio;
            win_idx_q  <= cmp_idx_q;
          end
          if (!issue && !cmp_vld_q) begin
            if (found_q) begin
              state_q <= S_READ;
            end else begin
              res_q.result_kind <= KIND_IDLE;
              time_q  <= time_inc;
              state_q <= S_OUT;
            end
          end
        end
        S_READ: begin
          state_q <= S_UPD;
        end
        S_UPD: begin
          res_q.result_kind  <= KIND_RUN;
          res_q.process_slot <= SLOT_W'(win_idx_q);
          if (!started_q[win_idx_q]) begin
            started_q[win_idx_q] <= 1'b1;
            res_q.first_run      <= 1'b1;
            res_q.response_time  <= time_q - rd_q.arrival;
          end
          time_q <= time_inc;
          if (rem_next == '0) begin
            finished_q[win_idx_q] <= 1'b1;
            res_q.completed       <= 1'b1;
            res_q.turnaround_time <= time_inc - rd_q.arrival;
          end
          state_q <= S_FIN;
        end
        S_FIN: begin
          // burst is unchanged by the write-back, so rd_q still holds it
          if (res_q.completed && (res_q.turnaround_time > rd_q.burst)) begin
            res_q.waiting_time <= res_q.turnaround_time - rd_q.burst;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_q   <= res_fin;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.result_kind     = out_q.result_kind;
  assign res_o.process_slot    = out_q.process_slot;
  assign res_o.load_rejected   = out_q.load_rejected;
  assign res_o.time_now        = out_q.time_now;
  assign res_o.first_run       = out_q.first_run;
  assign res_o.response_time   = out_q.response_time;
  assign res_o.completed       = out_q.completed;
  assign res_o.turnaround_time = out_q.turnaround_time;
  assign res_o.waiting_time    = out_q.waiting_time;
  assign res_o.all_finished    = out_q.all_finished;

endmodule

### rtl/pps_checker.sv
// port-level checks of the scheduler and their binding
`include "preemptive_priority_scheduler_defines.svh"

module pps_props import pps_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_ready_i,
  input logic              res_valid_i,
  input logic              res_ready_i,
  input logic [KIND_W-1:0] result_kind_i,
  input logic [SLOT_W-1:0] process_slot_i,
  input logic              first_run_i,
  input logic              completed_i,
  input logic [TIME_W-1:0] turnaround_time_i,
  input logic [TIME_W-1:0] waiting_time_i
);

  `PPS_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |-> !res_valid_i, "result valid in reset")
  `PPS_ASSERT(a_res_hold, res_valid_i && !res_ready_i |=> res_valid_i, "result dropped")
  `PPS_ASSERT(a_busy_after_req, req_valid_i && req_ready_i |=> !req_ready_i, "ready while busy")
  `PPS_ASSERT(a_idle_clean, res_valid_i && (result_kind_i == KIND_IDLE) |-> (process_slot_i == '0) && !first_run_i && !completed_i, "idle tick with process data")
  `PPS_ASSERT(a_wait_le_tat, res_valid_i && completed_i |-> (waiting_time_i <= turnaround_time_i), "waiting above turnaround")

endmodule

bind preemptive_priority_scheduler pps_props u_pps_props (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req_i.valid),
  .req_ready_i       (req_i.ready),
  .res_valid_i       (res_o.valid),
  .res_ready_i       (res_o.ready),
  .result_kind_i     (res_o.result_kind),
  .process_slot_i    (res_o.process_slot),
  .first_run_i       (res_o.first_run),
  .completed_i       (res_o.completed),
  .turnaround_time_i (res_o.turnaround_time),
  .waiting_time_i    (res_o.waiting_time)
);

### bench/pps_checker.sv
// scoreboard for the priority scheduler: predicts each result and compares it on transfer
`timescale 1ns / 1ps

module pps_checker import pps_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  pps_req_if   req_i,
  pps_res_if   res_i,
  output int   fail_cnt_o,
  output int   pending_o
);

  localparam int REPORT_CAP = 100;

  logic [TIME_W-1:0]  sched_time;
  int                 n_loaded;
  logic [TIME_W-1:0]  arrival_tab [MAX_PROCESSES];
  logic [BURST_W-1:0] burst_tab   [MAX_PROCESSES];
  logic [BURST_W-1:0] left_tab    [MAX_PROCESSES];
  logic [PRIO_W-1:0]  prio_tab    [MAX_PROCESSES];
  bit                 ran_before  [MAX_PROCESSES];
  bit                 done_tab    [MAX_PROCESSES];
  res_t               expected_q[$];
  int                 mismatches = 0;

  // advances the scheduler copy by one request and returns the result it must give
  function automatic res_t schedule_request(logic kind, logic [TIME_W-1:0] arr,
                                            logic [BURST_W-1:0] burst,
                                            logic [PRIO_W-1:0] prio);
    res_t              r;
    int                win;
    logic [TIME_W-1:0] tat;
    r   = '0;
    win = -1;
    if (kind == REQ_LOAD) begin
      r.result_kind = KIND_LOAD;
      if (n_loaded >= MAX_PROCESSES || burst == '0) begin
        r.load_rejected = 1'b1;
      end else begin
        arrival_tab[n_loaded] = arr;
        burst_tab[n_loaded]   = burst;
        left_tab[n_loaded]    = burst;
        prio_tab[n_loaded]    = prio;
        ran_before[n_loaded]  = 1'b0;
        done_tab[n_loaded]    = 1'b0;
        r.process_slot        = SLOT_W'(n_loaded);
        n_loaded++;
      end
    end else begin
      // strict compare keeps the lowest slot on equal priority
      for (int i = 0; i < n_loaded; i++) begin
        if (!done_tab[i] && arrival_tab[i] <= sched_time &&
            (win < 0 || prio_tab[i] < prio_tab[win]))
          win = i;
      end
      if (win < 0) begin
        r.result_kind = KIND_IDLE;
      end else begin
        r.result_kind  = KIND_RUN;
        r.process_slot = SLOT_W'(win);
        if (!ran_before[win]) begin
          ran_before[win] = 1'b1;
          r.first_run     = 1'b1;
          r.response_time = sched_time - arrival_tab[win];
        end
        if (left_tab[win] != '0) left_tab[win]--;
      end
      if (sched_time != TIME_MAX) sched_time++;
      if (win >= 0) begin
        if (left_tab[win] == '0) begin
          tat               = sched_time - arrival_tab[win];
          done_tab[win]     = 1'b1;
          r.completed       = 1'b1;
          r.turnaround_time = tat;
          // a saturated clock can make turnaround shorter than the burst
          r.waiting_time    = (tat > burst_tab[win]) ? tat - burst_tab[win] : '0;
        end
      end
    end
    r.time_now     = sched_time;
    r.all_finished = 1'b1;
    for (int i = 0; i < n_loaded; i++) begin
      if (!done_tab[i]) r.all_finished = 1'b0;
    end
    return r;
  endfunction

  function automatic void check_field(string fname, logic [TIME_W-1:0] want,
                                      logic [TIME_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      sched_time = '0;
      n_loaded   = 0;
      for (int i = 0; i < MAX_PROCESSES; i++) begin
        ran_before[i] = 1'b0;
        done_tab[i]   = 1'b0;
      end
      expected_q.delete();
      pending_o <= 0;
    end else begin
      // results first: a result never belongs to a request taken at the same edge
      if (res_i.valid && res_i.ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_CAP)
            $display("%0t: result with nothing expected, expected none, got kind %0d slot %0d",
                     $time, res_i.result_kind, res_i.process_slot);
        end else begin
          want = expected_q.pop_front();
          check_field("result_kind", want.result_kind, res_i.result_kind);
          check_field("process_slot", want.process_slot, res_i.process_slot);
          check_field("load_rejected", want.load_rejected, res_i.load_rejected);
          check_field("time_now", want.time_now, res_i.time_now);
          check_field("first_run", want.first_run, res_i.first_run);
          check_field("response_time", want.response_time, res_i.response_time);
          check_field("completed", want.completed, res_i.completed);
          check_field("turnaround_time", want.turnaround_time, res_i.turnaround_time);
          check_field("waiting_time", want.waiting_time, res_i.waiting_time);
          check_field("all_finished", want.all_finished, res_i.all_finished);
        end
      end
      if (req_i.valid && req_i.ready)
        expected_q.push_back(schedule_request(req_i.req_type, req_i.arrival_time,
                                              req_i.burst_time, req_i.priority_level));
      pending_o <= expected_q.size();
    end
    fail_cnt_o <= mismatches;
  end

endmodule

### bench/tb_top.sv
// testbench top for the priority scheduler: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
  import pps_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_ITEMS = 1850;
  localparam int LONG_HOLD_AT = 300;
  localparam int PAUSE_AT     = 1000;
  localparam int LONG_HOLD    = 600;
  localparam int STUCK_LIMIT  = 4000;
  localparam int END_CYCLES   = 40;

  logic clk_i;
  logic rst_ni;
  int   fail_cnt;
  int   pending;
  int   stuck_cycles = 0;
  bit   long_hold_req = 1'b0;

  // stimulus bookkeeping: exact clock value and fill level the block should be at
  logic [TIME_W-1:0] clock_est = '0;
  int                slots_used = 0;

  pps_req_if req_if ();
  pps_res_if res_if ();

  preemptive_priority_scheduler DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  pps_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .res_i      (res_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  task automatic send_req(input logic kind, input logic [TIME_W-1:0] arr,
                          input logic [BURST_W-1:0] burst, input logic [PRIO_W-1:0] prio);
    req_if.valid          <= 1'b1;
    req_if.req_type       <= kind;
    req_if.arrival_time   <= arr;
    req_if.burst_time     <= burst;
    req_if.priority_level <= prio;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    if (kind == REQ_TICK && clock_est != TIME_MAX) clock_est++;
    if (kind == REQ_LOAD && burst != '0 && slots_used < MAX_PROCESSES) slots_used++;
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic              is_load;
    logic [TIME_W-1:0] arr_r;
    logic [BURST_W-1:0] burst_r;
    logic [PRIO_W-1:0] prio_r;
    int                offset;
    int                pick;
    int                gap;
    rst_ni                <= 1'b0;
    req_if.valid          <= 1'b0;
    req_if.req_type       <= REQ_TICK;
    req_if.arrival_time   <= '0;
    req_if.burst_time     <= '0;
    req_if.priority_level <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, rejects, far arrival, ties, preemption
    send_req(REQ_TICK, '0, '0, '0);
    send_req(REQ_LOAD, '0, '0, '0);
    send_req(REQ_LOAD, '0, 16'd1, 8'd128);
    send_req(REQ_TICK, '1, '1, '1);
    send_req(REQ_LOAD, TIME_MAX, 16'd1, 8'd0);
    send_req(REQ_TICK, '0, '0, '0);
    // long low-priority job that outlasts the run
    send_req(REQ_LOAD, 16'd1, 16'hFFFF, 8'd255);
    send_req(REQ_LOAD, '0, 16'd2, 8'd255);
    send_req(REQ_TICK, '0, '0, '0);
    send_req(REQ_LOAD, 16'd5, 16'd3, 8'd7);
    send_req(REQ_TICK, '0, '0, '0);
    send_req(REQ_TICK, '0, '0, '0);
    send_req(REQ_TICK, '0, '0, '0);
    send_req(REQ_LOAD, 16'd2, 16'd1, 8'd7);
    repeat (6) send_req(REQ_TICK, '0, '0, '0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == LONG_HOLD_AT) long_hold_req = 1'b1;
      if (n == PAUSE_AT) drain_results();
      is_load = (slots_used < MAX_PROCESSES) ? ($urandom_range(0, 39) == 0)
                                             : ($urandom_range(0, 11) == 0);
      arr_r   = 16'($urandom);
      burst_r = 16'($urandom);
      prio_r  = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
      if (is_load) begin
        // mostly arrivals around the current clock, some anywhere
        if ($urandom_range(0, 3) != 0) begin
          offset = int'(clock_est) + int'($urandom_range(0, 60)) - 30;
          if (offset < 0) offset = 0;
          else if (offset > int'(TIME_MAX)) offset = int'(TIME_MAX);
          arr_r = TIME_W'(offset);
        end
        pick = $urandom_range(0, 29);
        if (pick == 0) begin
          burst_r = '0;
        end else if (pick <= 3) begin
          // huge bursts at the bottom priority so they never starve the rest
          prio_r = 8'd255;
        end else begin
          burst_r = BURST_W'($urandom_range(1, 40));
        end
      end
      send_req(is_load ? REQ_LOAD : REQ_TICK, arr_r, burst_r, prio_r);
      if (n % 200 >= 60 && $urandom_range(0, 2) == 0) begin
        gap = ($urandom_range(0, 14) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 3);
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end

    drain_results();
    repeat (END_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : result_sink
    int span;
    bit long_done;
    long_done = 1'b0;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (long_hold_req && !long_done) begin
        // long stall so the block backs up and holds off new requests
        long_done = 1'b1;
        res_if.ready <= 1'b0;
        span = LONG_HOLD;
      end else if ($urandom_range(0, 3) != 0) begin
        res_if.ready <= 1'b1;
        span = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                           : $urandom_range(1, 8);
      end else begin
        res_if.ready <= 1'b0;
        span = ($urandom_range(0, 14) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
      end
      repeat (span) @(posedge clk_i);
    end
  end

  // no transfer on either channel for too long means the block is hung
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

endmodule
